FILE: sv/gcb_pkg.sv
`default_nettype none

package gcb_pkg;

    localparam int MAX_LENGTH  = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int ACC_BITS    = 48;
    localparam int COEF_BITS   = 16;
    localparam int FRAC_BITS   = 14;
    localparam int LEN_BITS    = $clog2(MAX_LENGTH) + 1;
    localparam int CFG_BITS    = 16;
    localparam int PROD_W      = ACC_BITS + COEF_BITS + 1;
    localparam int SHIFT_BITS  = 4;

    localparam logic [LEN_BITS-1:0]     LEN_RESET = LEN_BITS'(256);
    localparam logic signed [COEF_BITS-1:0] COS_RESET = COEF_BITS'(16384);
    localparam logic signed [COEF_BITS-1:0] SIN_RESET = '0;

    localparam logic signed [PROD_W-1:0] ACC_MAX_W =
        {{(PROD_W-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] ACC_MIN_W = ~ACC_MAX_W;

    typedef enum logic [1:0] {
        CFG_BLOCK_LENGTH = 2'd0,
        CFG_COS_COEF     = 2'd1,
        CFG_SIN_COEF     = 2'd2
    } t_cfg_index;

    typedef logic signed [ACC_BITS-1:0]    t_acc;
    typedef logic signed [COEF_BITS-1:0]   t_coef;
    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample sample_re;
        t_sample sample_im;
    } t_in_word;

    typedef struct packed {
        t_acc bin_re;
        t_acc bin_im;
        logic saturated;
    } t_out_word;

    typedef struct packed {
        logic adv;
        logic clr;
    } t_lane_ctl;

    typedef struct packed {
        logic clip;
        t_acc val;
    } t_sat;

    function automatic t_sat sat_fit(input logic signed [PROD_W-1:0] v);
        t_sat r;
        if (v > ACC_MAX_W) begin
            r.clip = 1'b1;
            r.val  = ACC_MAX_W[ACC_BITS-1:0];
        end else if (v < ACC_MIN_W) begin
            r.clip = 1'b1;
            r.val  = ACC_MIN_W[ACC_BITS-1:0];
        end else begin
            r.clip = 1'b0;
            r.val  = v[ACC_BITS-1:0];
        end
        return r;
    endfunction

    function automatic t_sat sat_add(input t_acc a, input t_acc b);
        logic signed [PROD_W-1:0] s;
        s = PROD_W'(a) + PROD_W'(b);
        return sat_fit(s);
    endfunction

    function automatic t_sat sat_sub(input t_acc a, input t_acc b);
        logic signed [PROD_W-1:0] s;
        s = PROD_W'(a) - PROD_W'(b);
        return sat_fit(s);
    endfunction

    // round half up of a*c / 2^shift, saturated
    function automatic t_sat coef_mul(input t_acc a, input t_coef c,
                                      input logic [SHIFT_BITS-1:0] shift);
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] rnd;
        p   = PROD_W'(a) * PROD_W'(c);
        rnd = PROD_W'(1) << (shift - SHIFT_BITS'(1));
        p   = (p + rnd) >>> shift;
        return sat_fit(p);
    endfunction

endpackage

`default_nettype wire

FILE: sv/gcb_lane.sv
`default_nettype none

module gcb_lane
    import gcb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_lane_ctl i_ctl,
    input  wire t_sample   i_x,
    input  wire t_coef     i_cos,
    output t_acc           o_s,
    output t_acc           o_s1,
    output logic           o_clip
);

    t_acc r_recent;
    t_acc r_older;
    t_sat n_term;
    t_sat n_sum;
    t_sat n_s;

    always_comb begin
        n_term = coef_mul(r_recent, i_cos, SHIFT_BITS'(FRAC_BITS - 1));
        n_sum  = sat_add(ACC_BITS'(i_x), n_term.val);
        n_s    = sat_sub(n_sum.val, r_older);
    end

    assign o_s    = n_s.val;
    assign o_s1   = r_recent;
    assign o_clip = n_term.clip | n_sum.clip | n_s.clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= '0;
            r_older  <= '0;
        end else if (i_ctl.adv) begin
            if (i_ctl.clr) begin
                r_recent <= '0;
                r_older  <= '0;
            end else begin
                r_recent <= n_s.val;
                r_older  <= r_recent;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/goertzel_complex_bin_top.sv
// Single-bin Goertzel DFT over a stream of complex samples.
//
// Input channel: i_in_valid / o_in_stall carry one complex sample word.
// Output channel: o_out_valid / i_out_stall carry one bin word per block:
// real and imaginary bin values, saturated to 48 bits, and a sticky clip
// flag for the block.
// Config channel: i_cfg_valid / o_cfg_ready, index 0 block length,
// 1 cosine, 2 sine (Q2.14). Ready is always high; write only while idle.
//
// Throughput: one sample per cycle while o_in_stall is low. The recursion of
// each component is a 48x16 multiply, round, add and subtract closed
// combinationally around the state registers.
// The sample that ends a block passes through the capture, product and sum
// stages before its bin word is on the output.
// Reset returns length 256, cosine 1.0, sine 0 and an empty block.
// When the receiver stalls, finished words queue in the three output
// stages; o_in_stall rises only when all three hold a word.

`default_nettype none

module goertzel_complex_bin_top
    import gcb_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_in_word            i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_out_word                o_out_word,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [CFG_BITS-1:0] i_cfg_data
);

    typedef struct packed {
        t_acc  s_re;
        t_acc  s1_re;
        t_acc  s_im;
        t_acc  s1_im;
        t_coef cos_c;
        t_coef sin_c;
        logic  clip;
    } t_cap;

    typedef struct packed {
        t_acc cr;
        t_acc si;
        t_acc ci;
        t_acc sr;
        t_acc s1_re;
        t_acc s1_im;
        logic clip;
    } t_prod;

    logic [LEN_BITS-1:0] r_block_length;
    t_coef               r_cos;
    t_coef               r_sin;
    logic [LEN_BITS-1:0] r_count;
    logic                r_clip_seen;
    logic                r_a_valid;
    logic                r_b_valid;
    logic                r_c_valid;
    t_cap                r_a;
    t_prod               r_b;
    t_out_word           r_c;

    logic                accept;
    logic [LEN_BITS-1:0] len_eff;
    logic [LEN_BITS-1:0] n_count;
    logic                done;
    logic                n_clip;
    logic                c_ready;
    logic                b_ready;
    logic                b_move;
    logic                a_move;
    t_lane_ctl           lane_ctl;
    t_acc                s_re;
    t_acc                s1_re;
    t_acc                s_im;
    t_acc                s1_im;
    logic                clip_re;
    logic                clip_im;
    t_sat                p_cr;
    t_sat                p_si;
    t_sat                p_ci;
    t_sat                p_sr;
    t_sat                y_re0;
    t_sat                y_re;
    t_sat                y_im0;
    t_sat                y_im;
    t_prod               n_b;
    t_out_word           n_c;

    assign o_in_stall  = r_a_valid & r_b_valid & r_c_valid;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_c_valid;
    assign o_out_word  = r_c;

    assign c_ready = ~r_c_valid | ~i_out_stall;
    assign b_move  = r_b_valid & c_ready;
    assign b_ready = ~r_b_valid | c_ready;
    assign a_move  = r_a_valid & b_ready;

    always_comb begin
        if (r_block_length == '0) begin
            len_eff = LEN_BITS'(1);
        end else if (r_block_length > LEN_BITS'(MAX_LENGTH)) begin
            len_eff = LEN_BITS'(MAX_LENGTH);
        end else begin
            len_eff = r_block_length;
        end
        n_count = (r_count < len_eff) ? r_count + LEN_BITS'(1) : r_count;
        done    = (n_count >= len_eff);
        n_clip  = r_clip_seen | clip_re | clip_im;
    end

    assign lane_ctl.adv = accept;
    assign lane_ctl.clr = done;

    gcb_lane u_lane_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_x     (i_in_word.sample_re),
        .i_cos   (r_cos),
        .o_s     (s_re),
        .o_s1    (s1_re),
        .o_clip  (clip_re)
    );

    gcb_lane u_lane_im (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_x     (i_in_word.sample_im),
        .i_cos   (r_cos),
        .o_s     (s_im),
        .o_s1    (s1_im),
        .o_clip  (clip_im)
    );

    always_comb begin
        p_cr = coef_mul(r_a.s_re, r_a.cos_c, SHIFT_BITS'(FRAC_BITS));
        p_si = coef_mul(r_a.s_im, r_a.sin_c, SHIFT_BITS'(FRAC_BITS));
        p_ci = coef_mul(r_a.s_im, r_a.cos_c, SHIFT_BITS'(FRAC_BITS));
        p_sr = coef_mul(r_a.s_re, r_a.sin_c, SHIFT_BITS'(FRAC_BITS));
        n_b.cr    = p_cr.val;
        n_b.si    = p_si.val;
        n_b.ci    = p_ci.val;
        n_b.sr    = p_sr.val;
        n_b.s1_re = r_a.s1_re;
        n_b.s1_im = r_a.s1_im;
        n_b.clip  = r_a.clip | p_cr.clip | p_si.clip | p_ci.clip | p_sr.clip;
    end

    always_comb begin
        y_re0 = sat_sub(r_b.cr, r_b.si);
        y_re  = sat_sub(y_re0.val, r_b.s1_re);
        y_im0 = sat_add(r_b.ci, r_b.sr);
        y_im  = sat_sub(y_im0.val, r_b.s1_im);
        n_c.bin_re    = y_re.val;
        n_c.bin_im    = y_im.val;
        n_c.saturated = r_b.clip | y_re0.clip | y_re.clip | y_im0.clip | y_im.clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= LEN_RESET;
            r_cos          <= COS_RESET;
            r_sin          <= SIN_RESET;
            r_count        <= '0;
            r_clip_seen    <= 1'b0;
            r_a_valid      <= 1'b0;
            r_b_valid      <= 1'b0;
            r_c_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_BLOCK_LENGTH: r_block_length <= i_cfg_data[LEN_BITS-1:0];
                    CFG_COS_COEF:     r_cos          <= i_cfg_data;
                    CFG_SIN_COEF:     r_sin          <= i_cfg_data;
                    default:          ;
                endcase
            end
            if (accept) begin
                r_count     <= done ? '0 : n_count;
                r_clip_seen <= done ? 1'b0 : n_clip;
            end
            if (accept && done) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_b_valid <= 1'b1;
            end else if (b_move) begin
                r_b_valid <= 1'b0;
            end
            if (b_move) begin
                r_c_valid <= 1'b1;
            end else if (c_ready) begin
                r_c_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && done) begin
            r_a.s_re  <= s_re;
            r_a.s1_re <= s1_re;
            r_a.s_im  <= s_im;
            r_a.s1_im <= s1_im;
            r_a.cos_c <= r_cos;
            r_a.sin_c <= r_sin;
            r_a.clip  <= n_clip;
        end
        if (a_move) begin
            r_b <= n_b;
        end
        if (b_move) begin
            r_c <= n_c;
        end
    end

endmodule

`default_nettype wire

FILE: sv/gcb_checker.sv
`default_nettype none

module gcb_checker
    import gcb_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire t_out_word           o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed or dropped");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no output word pending");

    a_stall_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall && !i_out_stall |=> !o_in_stall)
        else $error("input stall held after output drained");

endmodule

bind goertzel_complex_bin_top gcb_checker u_gcb_checker (.*);

`default_nettype wire
